/* design/cblit_pkg.sv */
// ----------------------------------------------------------------------------
// cblit_pkg
// Shared codes and types of the clipped blit address generator.
// ----------------------------------------------------------------------------
package cblit_pkg;

  // Raster dimension and linear index widths
  localparam int unsigned DimW = 11;
  localparam int unsigned IdxW = 20;

  // Configuration register indexes
  localparam logic [1:0] RegDestWidth  = 2'd0;
  localparam logic [1:0] RegDestHeight = 2'd1;
  localparam logic [1:0] RegSrcWidth   = 2'd2;
  localparam logic [1:0] RegSrcHeight  = 2'd3;

  // Input item kinds
  localparam logic ActStart = 1'b0;
  localparam logic ActNext  = 1'b1;

  // One result item
  typedef struct packed {
    logic [IdxW-1:0] dest_index;
    logic [IdxW-1:0] src_index;
    logic            pair_valid;
    logic            last_pair;
    logic            empty_overlap;
  } result_t;

endpackage

/* design/clipped_blit_address_generator.sv */
// ----------------------------------------------------------------------------
// clipped_blit_address_generator
// Clips a source raster placed at a signed offset to the destination and
// streams the paired destination/source linear indices in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel   : writes dest_width, dest_height, src_width, src_height
//                   (index 0..3). Always ready; write only while idle.
//   s_axis        : one transfer per item. tuser = action (0 start, 1 next),
//                   tdata = {y_offset, x_offset}, x_offset in the low bits.
//   m_axis        : exactly one transfer per accepted item. tdata holds
//                   {src_index, dest_index}, tuser holds {empty_overlap,
//                   pair_valid}, tlast marks the final pair of a blit.
// Output: result is registered, valid in the cycle after the input transfer.
// Throughput: one item per clock unless stalled. Start clipping, both start-index
// multiplies and the per-pair step all resolve combinationally between the input
// handshake and the result register, so a next item may directly follow a start.
// Stall: the result register holds while m_axis_tready is low; s_axis_tready
// drops only while a result is held and the receiver is not taking it.
// Reset: registers return to 1x1 rasters, the generator goes idle and the
// output register empties. A next item while idle yields an all-zero result.
// ----------------------------------------------------------------------------
module clipped_blit_address_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [11:0] x_offset, [23:12] y_offset
  input  logic        s_axis_tuser_i,   // [0] action
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [19:0] dest_index, [39:20] src_index
  output logic [1:0]  m_axis_tuser_o,   // [0] pair_valid, [1] empty_overlap
  output logic        m_axis_tlast_o    // last_pair
);

  localparam int unsigned DimW = cblit_pkg::DimW;
  localparam int unsigned IdxW = cblit_pkg::IdxW;

  // configuration registers
  logic [DimW-1:0] dest_width_q, dest_height_q, src_width_q, src_height_q;

  // walk state
  logic [IdxW-1:0] dest_pos_q, dest_pos_d, src_pos_q, src_pos_d;
  logic [DimW-1:0] dest_skip_q, dest_skip_d, src_skip_q, src_skip_d;
  logic [DimW-1:0] run_width_q, run_width_d, col_cnt_q, col_cnt_d;
  logic [DimW-1:0] rows_left_q, rows_left_d;
  logic            busy_q, busy_d;

  // result register
  logic                result_valid_q;
  cblit_pkg::result_t  result_q, result_d;

  logic in_xfer;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !result_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // --- start: clip the left, top, right and bottom edges ---
  logic signed [13:0] xo, yo, x_end, y_end, x1, y1, x0, y0, w, h;
  logic signed [13:0] dw, dh, sw, sh;
  logic [11:0]        src_col, src_row;
  logic [21:0]        dest_prod;
  logic [22:0]        src_prod;
  logic               empty;

  always_comb begin
    xo = {{2{s_axis_tdata_i[11]}}, s_axis_tdata_i[11:0]};
    yo = {{2{s_axis_tdata_i[23]}}, s_axis_tdata_i[23:12]};
    dw = signed'({3'b000, dest_width_q});
    dh = signed'({3'b000, dest_height_q});
    sw = signed'({3'b000, src_width_q});
    sh = signed'({3'b000, src_height_q});
    x0 = (xo > 14'sd0) ? xo : 14'sd0;
    y0 = (yo > 14'sd0) ? yo : 14'sd0;
    x_end = xo + sw;
    y_end = yo + sh;
    x1 = (x_end < dw) ? x_end : dw;
    y1 = (y_end < dh) ? y_end : dh;
    w  = x1 - x0;
    h  = y1 - y0;
    empty = (w <= 14'sd0) || (h <= 14'sd0);
    // source column/row of the clipped corner, never negative
    src_col = 12'(x0 - xo);
    src_row = 12'(y0 - yo);
    dest_prod = 22'(y0[DimW-1:0]) * 22'(dest_width_q);
    src_prod  = 23'(src_row) * 23'(src_width_q);
  end

  // --- next: step one pair ---
  logic [DimW-1:0] col_inc, rows_dec;
  logic            row_end;

  always_comb begin
    col_inc  = col_cnt_q + DimW'(1);
    row_end  = (col_inc >= run_width_q);
    rows_dec = rows_left_q - DimW'(1);
  end

  always_comb begin
    dest_pos_d  = dest_pos_q;
    src_pos_d   = src_pos_q;
    dest_skip_d = dest_skip_q;
    src_skip_d  = src_skip_q;
    run_width_d = run_width_q;
    col_cnt_d   = col_cnt_q;
    rows_left_d = rows_left_q;
    busy_d      = busy_q;
    result_d    = '0;
    if (s_axis_tuser_i == cblit_pkg::ActStart) begin
      col_cnt_d = '0;
      if (empty) begin
        busy_d      = 1'b0;
        rows_left_d = '0;
        run_width_d = '0;
        dest_pos_d  = '0;
        src_pos_d   = '0;
        dest_skip_d = '0;
        src_skip_d  = '0;
        result_d.empty_overlap = 1'b1;
      end else begin
        busy_d      = 1'b1;
        run_width_d = w[DimW-1:0];
        rows_left_d = h[DimW-1:0];
        dest_pos_d  = dest_prod[IdxW-1:0] + IdxW'(x0[DimW-1:0]);
        src_pos_d   = src_prod[IdxW-1:0] + IdxW'(src_col);
        dest_skip_d = dest_width_q - w[DimW-1:0];
        src_skip_d  = src_width_q - w[DimW-1:0];
      end
    end else if (busy_q) begin
      result_d.dest_index = dest_pos_q;
      result_d.src_index  = src_pos_q;
      result_d.pair_valid = 1'b1;
      if (row_end) begin
        col_cnt_d   = '0;
        dest_pos_d  = dest_pos_q + IdxW'(1) + IdxW'(dest_skip_q);
        src_pos_d   = src_pos_q + IdxW'(1) + IdxW'(src_skip_q);
        rows_left_d = rows_dec;
        if (rows_dec == '0) begin
          busy_d             = 1'b0;
          result_d.last_pair = 1'b1;
        end
      end else begin
        col_cnt_d  = col_inc;
        dest_pos_d = dest_pos_q + IdxW'(1);
        src_pos_d  = src_pos_q + IdxW'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_width_q  <= DimW'(1);
      dest_height_q <= DimW'(1);
      src_width_q   <= DimW'(1);
      src_height_q  <= DimW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cblit_pkg::RegDestWidth:  dest_width_q  <= cfg_data_i;
        cblit_pkg::RegDestHeight: dest_height_q <= cfg_data_i;
        cblit_pkg::RegSrcWidth:   src_width_q   <= cfg_data_i;
        cblit_pkg::RegSrcHeight:  src_height_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // walk state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_pos_q     <= '0;
      src_pos_q      <= '0;
      dest_skip_q    <= '0;
      src_skip_q     <= '0;
      run_width_q    <= '0;
      col_cnt_q      <= '0;
      rows_left_q    <= '0;
      busy_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        dest_pos_q  <= dest_pos_d;
        src_pos_q   <= src_pos_d;
        dest_skip_q <= dest_skip_d;
        src_skip_q  <= src_skip_d;
        run_width_q <= run_width_d;
        col_cnt_q   <= col_cnt_d;
        rows_left_q <= rows_left_d;
        busy_q      <= busy_d;
      end
      if (in_xfer) begin
        result_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        result_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = result_valid_q;
  assign m_axis_tdata_o  = {result_q.src_index, result_q.dest_index};
  assign m_axis_tuser_o  = {result_q.empty_overlap, result_q.pair_valid};
  assign m_axis_tlast_o  = result_q.last_pair;

endmodule
